// File: rtl/mrtu_pkg.sv
`timescale 1ns / 1ps
// shared types, protocol constants and crc helper for the modbus rtu responder
// no dependencies

package mrtu_pkg;

  localparam logic [7:0]  ADDR_RESET       = 8'h01;
  localparam logic [7:0]  FUNC_READ        = 8'h03;
  localparam logic [7:0]  FUNC_WRITE       = 8'h06;
  localparam logic [7:0]  EXC_FLAG         = 8'h80;
  localparam logic [7:0]  EXC_ILLEGAL_FUNC = 8'h01;
  localparam logic [7:0]  EXC_ILLEGAL_ADDR = 8'h02;
  localparam logic [7:0]  BYTE_ZERO        = 8'h00;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;

  localparam int HEAD_LEN       = 8;
  localparam int WRITE_LAST_IDX = 5;
  localparam int EXC_LAST_IDX   = 2;
  localparam int CMDQ_DEPTH     = 2;
  localparam int CMDQ_PTR_W     = $clog2(CMDQ_DEPTH);

  typedef enum logic [1:0] {
    CMD_READ,
    CMD_WRITE,
    CMD_EXC
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] addr;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
  } cmd_t;

  typedef enum logic {
    FE_RECV,
    FE_EVAL
  } fe_state_t;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_DATA,
    BE_CRC_LO,
    BE_CRC_HI
  } be_state_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/mrtu_front.sv
`timescale 1ns / 1ps
// receive side: collects request bytes, runs the frame crc and classifies the request
// depends on mrtu_pkg

module mrtu_front #(
  parameter int NUM_REGS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_slave_address,
  input  logic [7:0]    in_rx_byte,
  input  logic          in_frame_end,
  input  logic          in_push,
  output logic          in_full,
  output logic          q_push,
  output mrtu_pkg::cmd_t q_cmd,
  input  logic          q_full
);

  mrtu_pkg::fe_state_t state_r, state_nxt;

  logic [7:0]  addr_r;
  logic [7:0]  head_r [mrtu_pkg::HEAD_LEN];
  logic [3:0]  cnt_r;
  logic [15:0] crc_r;
  logic [15:0] last2_r;

  logic        accept;
  logic        frame_ok;
  logic        frame_clr;
  logic [15:0] start_w;
  logic [15:0] qty_w;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;
  assign start_w   = {head_r[2], head_r[3]};
  assign qty_w     = {head_r[4], head_r[5]};
  assign frame_ok  = (head_r[0] == addr_r) && ({last2_r[7:0], last2_r[15:8]} == crc_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mrtu_pkg::FE_RECV: begin
        if (accept && in_frame_end) state_nxt = mrtu_pkg::FE_EVAL;
      end
      mrtu_pkg::FE_EVAL: begin
        if (!frame_ok || !q_full) state_nxt = mrtu_pkg::FE_RECV;
      end
      default: state_nxt = mrtu_pkg::FE_RECV;
    endcase
  end

  // outputs
  always_comb begin
    in_full   = 1'b0;
    q_push    = 1'b0;
    frame_clr = 1'b0;
    unique case (state_r)
      mrtu_pkg::FE_RECV: begin
        in_full = 1'b0;
      end
      mrtu_pkg::FE_EVAL: begin
        in_full   = 1'b1;
        q_push    = frame_ok && !q_full;
        frame_clr = !frame_ok || !q_full;
      end
      default: in_full = 1'b1;
    endcase
  end

  // request classification
  always_comb begin
    q_cmd.kind = mrtu_pkg::CMD_EXC;
    q_cmd.addr = head_r[0];
    q_cmd.b1   = head_r[1] + mrtu_pkg::EXC_FLAG;
    q_cmd.b2   = mrtu_pkg::EXC_ILLEGAL_FUNC;
    q_cmd.b3   = head_r[3];
    q_cmd.b4   = head_r[4];
    q_cmd.b5   = head_r[5];
    if (head_r[1] == mrtu_pkg::FUNC_READ) begin
      if (start_w == 16'h0000 && qty_w == 16'(NUM_REGS)) begin
        q_cmd.kind = mrtu_pkg::CMD_READ;
        q_cmd.b1   = mrtu_pkg::FUNC_READ;
        q_cmd.b2   = 8'(2 * NUM_REGS);
      end else begin
        q_cmd.b2 = mrtu_pkg::EXC_ILLEGAL_ADDR;
      end
    end else if (head_r[1] == mrtu_pkg::FUNC_WRITE) begin
      if (head_r[2] == mrtu_pkg::BYTE_ZERO && head_r[3] < 8'(NUM_REGS)) begin
        q_cmd.kind = mrtu_pkg::CMD_WRITE;
        q_cmd.b1   = mrtu_pkg::FUNC_WRITE;
        q_cmd.b2   = head_r[2];
      end else begin
        q_cmd.b2 = mrtu_pkg::EXC_ILLEGAL_ADDR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrtu_pkg::FE_RECV;
      addr_r  <= mrtu_pkg::ADDR_RESET;
      cnt_r   <= 4'd0;
      crc_r   <= mrtu_pkg::CRC_INIT;
      last2_r <= 16'h0000;
      for (int i = 0; i < mrtu_pkg::HEAD_LEN; i++) begin
        head_r[i] <= 8'h00;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) addr_r <= cfg_slave_address;
      if (frame_clr) begin
        cnt_r   <= 4'd0;
        crc_r   <= mrtu_pkg::CRC_INIT;
        last2_r <= 16'h0000;
        for (int i = 0; i < mrtu_pkg::HEAD_LEN; i++) begin
          head_r[i] <= 8'h00;
        end
      end else if (accept) begin
        if (cnt_r < 4'(mrtu_pkg::HEAD_LEN)) begin
          head_r[cnt_r[2:0]] <= in_rx_byte;
          cnt_r              <= cnt_r + 4'd1;
        end
        if (cnt_r >= 4'd2) crc_r <= mrtu_pkg::crc_feed(crc_r, last2_r[15:8]);
        last2_r <= {last2_r[7:0], in_rx_byte};
      end
    end
  end

endmodule

// File: rtl/mrtu_cmdq.sv
`timescale 1ns / 1ps
// two-entry queue of classified requests between receive and transmit sides
// depends on mrtu_pkg

module mrtu_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mrtu_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output mrtu_pkg::cmd_t pop_cmd,
  output logic           empty
);

  localparam int CNT_W = $clog2(mrtu_pkg::CMDQ_DEPTH + 1);

  mrtu_pkg::cmd_t                 ent_r [mrtu_pkg::CMDQ_DEPTH];
  logic [mrtu_pkg::CMDQ_PTR_W-1:0] wr_r;
  logic [mrtu_pkg::CMDQ_PTR_W-1:0] rd_r;
  logic [CNT_W-1:0]                cnt_r;
  logic                            do_push;
  logic                            do_pop;

  assign full    = (cnt_r == CNT_W'(mrtu_pkg::CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == mrtu_pkg::CMDQ_PTR_W'(mrtu_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == mrtu_pkg::CMDQ_PTR_W'(mrtu_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// File: rtl/mrtu_back.sv
`timescale 1ns / 1ps
// transmit side: holds the register bank, builds each response word and its crc
// depends on mrtu_pkg

module mrtu_back #(
  parameter int NUM_REGS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  mrtu_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic [7:0]     out_tx_byte,
  output logic           out_tx_last,
  output logic           out_empty,
  input  logic           out_pop
);

  localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int LEN_W = $clog2(2 * NUM_REGS + 3);

  mrtu_pkg::be_state_t state_r, state_nxt;

  mrtu_pkg::cmd_t cmd_r;
  logic [15:0]    regs_r [NUM_REGS];
  logic [LEN_W-1:0] cnt_r;
  logic [15:0]    crc_r;
  logic [7:0]     obyte_r;
  logic           olast_r;
  logic           ovalid_r;

  logic             slot_free;
  logic             load;
  logic [7:0]       load_byte;
  logic             load_last;
  logic [LEN_W-1:0] last_idx;
  logic [LEN_W-1:0] pos;
  logic [IDX_W-1:0] ridx;
  logic [15:0]      rword;
  logic [7:0]       data_byte;

  assign out_tx_byte = obyte_r;
  assign out_tx_last = olast_r;
  assign out_empty   = !ovalid_r;
  assign slot_free   = !ovalid_r || out_pop;

  assign pos   = cnt_r - LEN_W'(3);
  assign ridx  = IDX_W'(pos >> 1);
  assign rword = regs_r[ridx];

  always_comb begin
    unique case (cmd_r.kind)
      mrtu_pkg::CMD_READ:  last_idx = LEN_W'(2 + 2 * NUM_REGS);
      mrtu_pkg::CMD_WRITE: last_idx = LEN_W'(mrtu_pkg::WRITE_LAST_IDX);
      default:             last_idx = LEN_W'(mrtu_pkg::EXC_LAST_IDX);
    endcase
  end

  always_comb begin
    if (cmd_r.kind == mrtu_pkg::CMD_READ && cnt_r >= LEN_W'(3)) begin
      data_byte = pos[0] ? rword[7:0] : rword[15:8];
    end else begin
      case (cnt_r[2:0])
        3'd0:    data_byte = cmd_r.addr;
        3'd1:    data_byte = cmd_r.b1;
        3'd2:    data_byte = cmd_r.b2;
        3'd3:    data_byte = cmd_r.b3;
        3'd4:    data_byte = cmd_r.b4;
        3'd5:    data_byte = cmd_r.b5;
        default: data_byte = mrtu_pkg::BYTE_ZERO;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mrtu_pkg::BE_IDLE: begin
        if (!q_empty) state_nxt = mrtu_pkg::BE_DATA;
      end
      mrtu_pkg::BE_DATA: begin
        if (slot_free && cnt_r == last_idx) state_nxt = mrtu_pkg::BE_CRC_LO;
      end
      mrtu_pkg::BE_CRC_LO: begin
        if (slot_free) state_nxt = mrtu_pkg::BE_CRC_HI;
      end
      mrtu_pkg::BE_CRC_HI: begin
        if (slot_free) state_nxt = mrtu_pkg::BE_IDLE;
      end
      default: state_nxt = mrtu_pkg::BE_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = 1'b0;
    load      = 1'b0;
    load_byte = data_byte;
    load_last = 1'b0;
    unique case (state_r)
      mrtu_pkg::BE_IDLE: begin
        q_pop = !q_empty;
      end
      mrtu_pkg::BE_DATA: begin
        load = slot_free;
      end
      mrtu_pkg::BE_CRC_LO: begin
        load      = slot_free;
        load_byte = crc_r[7:0];
      end
      mrtu_pkg::BE_CRC_HI: begin
        load      = slot_free;
        load_byte = crc_r[15:8];
        load_last = 1'b1;
      end
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_cmd;
    if (load) begin
      obyte_r <= load_byte;
      olast_r <= load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mrtu_pkg::BE_IDLE;
      ovalid_r <= 1'b0;
      cnt_r    <= '0;
      crc_r    <= mrtu_pkg::CRC_INIT;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= 16'h0000;
      end
    end else begin
      state_r <= state_nxt;
      if (load) ovalid_r <= 1'b1;
      else if (out_pop) ovalid_r <= 1'b0;
      if (q_pop) begin
        cnt_r <= '0;
        crc_r <= mrtu_pkg::CRC_INIT;
        if (q_cmd.kind == mrtu_pkg::CMD_WRITE) begin
          regs_r[q_cmd.b3[IDX_W-1:0]] <= {q_cmd.b4, q_cmd.b5};
        end
      end else if (load && state_r == mrtu_pkg::BE_DATA) begin
        cnt_r <= cnt_r + 1'b1;
        crc_r <= mrtu_pkg::crc_feed(crc_r, data_byte);
      end
    end
  end

endmodule

// File: rtl/modbus_rtu_slave_register_responder.sv
`timescale 1ns / 1ps
// Modbus RTU slave answering read-all (function 3) and write-one (function 6) requests
// over a bank of NUM_REGS holding registers. The word that ends a frame is followed by the
// address, crc and function checks, during which full is high, stretched for as long as both
// request queue entries are taken. Responses leave one word per cycle while pop is held, after
// an idle state in which the transmit side takes the next request: a read answer is
// 5 + 2*NUM_REGS words, a write echo 8 and an exception 5. Two checked requests can wait
// between receive and transmit, so a new frame is taken while an answer is still going out.
// Frames with a wrong address or crc are dropped silently. Depends on mrtu_pkg, mrtu_front,
// mrtu_cmdq and mrtu_back.

module modbus_rtu_slave_register_responder #(
  parameter int NUM_REGS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_slave_address,
  input  logic [7:0] in_rx_byte,
  input  logic       in_frame_end,
  input  logic       in_push,
  output logic       in_full,
  output logic [7:0] out_tx_byte,
  output logic       out_tx_last,
  output logic       out_empty,
  input  logic       out_pop
);

  mrtu_pkg::cmd_t push_cmd;
  mrtu_pkg::cmd_t pop_cmd;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;

  mrtu_front #(
    .NUM_REGS (NUM_REGS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_slave_address (cfg_slave_address),
    .in_rx_byte        (in_rx_byte),
    .in_frame_end      (in_frame_end),
    .in_push           (in_push),
    .in_full           (in_full),
    .q_push            (q_push),
    .q_cmd             (push_cmd),
    .q_full            (q_full)
  );

  mrtu_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  mrtu_back #(
    .NUM_REGS (NUM_REGS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_cmd       (pop_cmd),
    .q_pop       (q_pop),
    .out_tx_byte (out_tx_byte),
    .out_tx_last (out_tx_last),
    .out_empty   (out_empty),
    .out_pop     (out_pop)
  );

endmodule

// File: test/mrtu_resp_checker.sv
`timescale 1ns / 1ps
// response checker for the modbus rtu register responder: watches the config, request and
// response channels, predicts every response word and compares them in order
// depends on mrtu_pkg

module mrtu_resp_checker #(
  parameter int NUM_REGS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_slave_address,
  input  logic [7:0] in_rx_byte,
  input  logic       in_frame_end,
  input  logic       in_push,
  input  logic       in_full,
  input  logic [7:0] out_tx_byte,
  input  logic       out_tx_last,
  input  logic       out_empty,
  input  logic       out_pop,
  output int         err_cnt,
  output int         pending
);

  localparam int RSP_MAX = 5 + 2 * NUM_REGS;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tx_word_t;

  tx_word_t    tx_expect_q[$];
  tx_word_t    want;
  logic [7:0]  slave_addr;
  logic [7:0]  head[mrtu_pkg::HEAD_LEN];
  logic [7:0]  rx_cnt;
  logic [15:0] rx_crc_acc;
  logic [15:0] tail_bytes;
  logic [15:0] regs[NUM_REGS];
  logic [7:0]  rsp_buf[RSP_MAX];
  int          fails = 0;

  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ mrtu_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  task automatic clear_frame();
    for (int i = 0; i < mrtu_pkg::HEAD_LEN; i++) head[i] = mrtu_pkg::BYTE_ZERO;
    rx_cnt = 8'd0;
    rx_crc_acc = mrtu_pkg::CRC_INIT;
    tail_bytes = 16'h0000;
  endtask

  // seal rsp_buf with its crc, low byte first, and queue every word
  task automatic emit_response(input int len);
    logic [15:0] c;
    tx_word_t w;
    c = mrtu_pkg::CRC_INIT;
    for (int i = 0; i < len; i++) c = crc16_step(c, rsp_buf[i]);
    rsp_buf[len] = c[7:0];
    rsp_buf[len + 1] = c[15:8];
    for (int i = 0; i < len + 2; i++) begin
      w.data = rsp_buf[i];
      w.last = (i == len + 1);
      tx_expect_q.push_back(w);
    end
  endtask

  task automatic exception_response(input logic [7:0] code);
    rsp_buf[0] = slave_addr;
    rsp_buf[1] = head[1] + mrtu_pkg::EXC_FLAG;
    rsp_buf[2] = code;
    emit_response(3);
  endtask

  task automatic answer_frame();
    logic [15:0] got_crc;
    got_crc = {tail_bytes[7:0], tail_bytes[15:8]};
    if (head[0] == slave_addr && got_crc == rx_crc_acc) begin
      if (head[1] == mrtu_pkg::FUNC_READ) begin
        if ({head[2], head[3]} != 16'd0 || {head[4], head[5]} != 16'(NUM_REGS)) begin
          exception_response(mrtu_pkg::EXC_ILLEGAL_ADDR);
        end else begin
          rsp_buf[0] = slave_addr;
          rsp_buf[1] = mrtu_pkg::FUNC_READ;
          rsp_buf[2] = 8'(2 * NUM_REGS);
          for (int i = 0; i < NUM_REGS; i++) begin
            rsp_buf[3 + 2 * i] = regs[i][15:8];
            rsp_buf[4 + 2 * i] = regs[i][7:0];
          end
          emit_response(3 + 2 * NUM_REGS);
        end
      end else if (head[1] == mrtu_pkg::FUNC_WRITE) begin
        if (head[2] != mrtu_pkg::BYTE_ZERO || int'(head[3]) >= NUM_REGS) begin
          exception_response(mrtu_pkg::EXC_ILLEGAL_ADDR);
        end else begin
          regs[int'(head[3])] = {head[4], head[5]};
          rsp_buf[0] = slave_addr;
          rsp_buf[1] = mrtu_pkg::FUNC_WRITE;
          for (int i = 2; i < 6; i++) rsp_buf[i] = head[i];
          emit_response(6);
        end
      end else begin
        exception_response(mrtu_pkg::EXC_ILLEGAL_FUNC);
      end
    end
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last);
    if (rx_cnt < 8'(mrtu_pkg::HEAD_LEN)) head[rx_cnt[2:0]] = b;
    if (rx_cnt >= 8'd2) rx_crc_acc = crc16_step(rx_crc_acc, tail_bytes[15:8]);
    tail_bytes = {tail_bytes[7:0], b};
    if (rx_cnt != 8'hFF) rx_cnt = rx_cnt + 8'd1;
    if (last) begin
      answer_frame();
      clear_frame();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      slave_addr = mrtu_pkg::ADDR_RESET;
      clear_frame();
      for (int i = 0; i < NUM_REGS; i++) regs[i] = 16'h0000;
      tx_expect_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) slave_addr = cfg_slave_address;
      if (out_pop && !out_empty) begin
        if (tx_expect_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("unexpected word: byte %h last %b", out_tx_byte, out_tx_last);
          end
        end else begin
          want = tx_expect_q.pop_front();
          if (want.data !== out_tx_byte || want.last !== out_tx_last) begin
            fails++;
            if (fails <= 10) begin
              $display("word mismatch: expected byte %h last %b, got byte %h last %b",
                       want.data, want.last, out_tx_byte, out_tx_last);
            end
          end
        end
      end
      if (in_push && !in_full) take_byte(in_rx_byte, in_frame_end);
    end
    pending <= tx_expect_q.size();
    err_cnt <= fails;
  end

endmodule

// File: test/tb_modbus_rtu_slave_register_responder.sv
`timescale 1ns / 1ps
// testbench top for the modbus rtu register responder: drives request frames and address
// writes with bursty pacing and a stalling receiver, then reports the verdict
// depends on mrtu_pkg, mrtu_resp_checker and the responder rtl

module tb_modbus_rtu_slave_register_responder;

  localparam int NUM_REGS = 16;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [7:0] cfg_slave_address = mrtu_pkg::ADDR_RESET;
  logic [7:0] in_rx_byte = 8'h00;
  logic       in_frame_end = 1'b0;
  logic       in_push = 1'b0;
  logic       out_pop = 1'b0;
  logic       cfg_ready;
  logic       in_full;
  logic [7:0] out_tx_byte;
  logic       out_tx_last;
  logic       out_empty;
  int         err_cnt;
  int         pending;

  logic [7:0] frame_q[$];
  logic [7:0] cur_addr = mrtu_pkg::ADDR_RESET;
  int         burst_left = 0;
  int         items_sent = 0;
  int         hold_req = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         pop_mode = 0;
  int         mode_left = 0;

  modbus_rtu_slave_register_responder #(.NUM_REGS(NUM_REGS)) u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_slave_address(cfg_slave_address),
    .in_rx_byte(in_rx_byte), .in_frame_end(in_frame_end), .in_push(in_push), .in_full(in_full),
    .out_tx_byte(out_tx_byte), .out_tx_last(out_tx_last), .out_empty(out_empty),
    .out_pop(out_pop)
  );

  mrtu_resp_checker #(.NUM_REGS(NUM_REGS)) u_chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_slave_address(cfg_slave_address),
    .in_rx_byte(in_rx_byte), .in_frame_end(in_frame_end), .in_push(in_push), .in_full(in_full),
    .out_tx_byte(out_tx_byte), .out_tx_last(out_tx_last), .out_empty(out_empty),
    .out_pop(out_pop), .err_cnt(err_cnt), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: random pop pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        pop_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (pop_mode)
        0: out_pop <= 1'b1;
        1: out_pop <= 1'($urandom_range(0, 1));
        default: out_pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic logic [15:0] frame_crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ mrtu_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  task automatic push_word(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      in_push <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_push <= 1'b1;
    in_rx_byte <= b;
    in_frame_end <= last;
    do @(posedge clk); while (in_full);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) push_word(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic append_crc(input bit corrupt);
    logic [15:0] c;
    c = mrtu_pkg::CRC_INIT;
    foreach (frame_q[i]) c = frame_crc_step(c, frame_q[i]);
    if (corrupt) c = c ^ (16'h0001 << $urandom_range(0, 15));
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
  endtask

  task automatic rand_frame();
    logic [7:0] a;
    int kind;
    int n;
    frame_q.delete();
    a = ($urandom_range(0, 9) < 8) ? cur_addr : 8'($urandom);
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      frame_q = {a, mrtu_pkg::FUNC_READ, mrtu_pkg::BYTE_ZERO, mrtu_pkg::BYTE_ZERO,
                 mrtu_pkg::BYTE_ZERO, 8'(NUM_REGS)};
      if ($urandom_range(0, 4) == 0) frame_q[$urandom_range(2, 5)] = 8'($urandom);
    end else if (kind < 8) begin
      frame_q = {a, mrtu_pkg::FUNC_WRITE, mrtu_pkg::BYTE_ZERO,
                 8'($urandom_range(0, NUM_REGS - 1)), 8'($urandom), 8'($urandom)};
      if ($urandom_range(0, 5) == 0) frame_q[$urandom_range(2, 3)] = 8'($urandom);
    end else begin
      frame_q = {a};
      n = (kind == 8) ? $urandom_range(1, 6) : $urandom_range(0, 10);
      repeat (n) frame_q.push_back(8'($urandom));
    end
    append_crc($urandom_range(0, 9) == 0);
  endtask

  task automatic run_random(input int upto);
    while (items_sent < upto) begin
      rand_frame();
      send_frame();
    end
  endtask

  task automatic settle();
    in_push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_address(input logic [7:0] a);
    settle();
    cfg_valid <= 1'b1;
    cfg_slave_address <= a;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_addr = a;
  endtask

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset address, directed frames
    frame_q = {cur_addr, mrtu_pkg::FUNC_WRITE, mrtu_pkg::BYTE_ZERO, 8'(NUM_REGS - 1),
               8'hFF, 8'hFF};
    append_crc(1'b0);
    send_frame();
    frame_q = {cur_addr, mrtu_pkg::FUNC_READ, mrtu_pkg::BYTE_ZERO, mrtu_pkg::BYTE_ZERO,
               mrtu_pkg::BYTE_ZERO, 8'(NUM_REGS)};
    append_crc(1'b0);
    send_frame();
    frame_q = {8'hFF};
    send_frame();
    frame_q = {cur_addr, mrtu_pkg::BYTE_ZERO};
    append_crc(1'b0);
    send_frame();
    run_random(80);

    set_address(8'h00);
    run_random(150);

    // two-byte frame whose crc region is empty
    set_address(8'hFF);
    frame_q = {8'hFF, 8'hFF};
    send_frame();
    run_random(items_sent + 30);
    hold_req++;
    run_random(220);

    // long frame, bytes past the head feed only the crc
    set_address(8'($urandom_range(1, 254)));
    run_random(250);
    frame_q = {cur_addr, mrtu_pkg::FUNC_WRITE, mrtu_pkg::BYTE_ZERO, 8'h03, 8'h12, 8'h34};
    repeat (40) frame_q.push_back(8'($urandom));
    append_crc(1'b0);
    send_frame();
    frame_q = {cur_addr, mrtu_pkg::FUNC_READ, mrtu_pkg::BYTE_ZERO, mrtu_pkg::BYTE_ZERO,
               mrtu_pkg::BYTE_ZERO, 8'(NUM_REGS)};
    append_crc(1'b0);
    send_frame();

    settle();
    repeat (50) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mrtu_pkg.sv
rtl/mrtu_front.sv
rtl/mrtu_cmdq.sv
rtl/mrtu_back.sv
rtl/modbus_rtu_slave_register_responder.sv
test/mrtu_resp_checker.sv
test/tb_modbus_rtu_slave_register_responder.sv
